@@ design/kdpt_pkg.sv @@
`timescale 1ns / 1ps

package kdpt_pkg;

  // Number of keys served and width of the stored tick values
  localparam int NUM_KEYS  = 4;
  localparam int TICK_BITS = 32;

  // Field widths of the stream payloads
  localparam int KEY_W   = 2;
  localparam int TIN_W   = 32;
  localparam int DUR_W   = 32;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;

  // Item operations carried in in_tuser
  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Per-key debounce phase, one-hot
  typedef enum logic [3:0] {
    PH_UP      = 4'b0001,
    PH_FALLING = 4'b0010,
    PH_DOWN    = 4'b0100,
    PH_RISING  = 4'b1000
  } phase_t;

  // Event codes reported in out_tuser
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } event_t;

  // Stored state of one key
  typedef struct packed {
    phase_t                 phase;
    logic [TICK_BITS-1:0]   start_tick;
    logic [TICK_BITS-1:0]   duration;
    logic                   present;
  } key_state_t;

  // Result of one item
  typedef struct packed {
    event_t                 ev;
    logic [DUR_W-1:0]       press_duration;
    logic                   duration_valid;
  } key_result_t;

endpackage

@@ design/kdpt_key_unit.sv @@
`timescale 1ns / 1ps

module kdpt_key_unit
  import kdpt_pkg::*;
(
  input  logic                 operation,
  input  logic                 key_level,
  input  logic [TIN_W-1:0]     tick,
  input  key_state_t           cur,
  output key_state_t           nxt,
  output key_result_t          res
);

  logic                 pressed;
  logic [TICK_BITS-1:0] now;
  event_t               ev;

  assign pressed = ~key_level;
  assign now     = TICK_BITS'(tick);

  // Advance the debounce machine of the addressed key
  always_comb begin
    nxt = cur;
    ev  = EV_NONE;
    if (operation == OP_CLEAR) begin
      nxt.present  = 1'b0;
      nxt.duration = '0;
    end else begin
      unique case (cur.phase)
        PH_UP: begin
          if (pressed) nxt.phase = PH_FALLING;
        end
        PH_FALLING: begin
          if (pressed) begin
            nxt.phase      = PH_DOWN;
            nxt.start_tick = now;
            ev             = EV_DOWN;
          end else begin
            nxt.phase = PH_UP;
          end
        end
        PH_DOWN: begin
          if (!pressed) nxt.phase = PH_RISING;
        end
        PH_RISING: begin
          if (!pressed) begin
            nxt.phase    = PH_UP;
            nxt.duration = now - cur.start_tick;
            nxt.present  = 1'b1;
            ev           = EV_UP;
          end else begin
            nxt.phase = PH_DOWN;
          end
        end
        default: nxt.phase = PH_UP;
      endcase
    end
  end

  // Report the duration as it stands after this item
  always_comb begin
    res.ev             = ev;
    res.duration_valid = nxt.present;
    res.press_duration = nxt.present ? DUR_W'(nxt.duration) : '0;
  end

endmodule

@@ design/key_debounce_press_timer.sv @@
`timescale 1ns / 1ps
// An accepted input transaction passes through the input register, then the
// result register, before its result transaction is offered on the output.
// Throughput: one item per cycle while out_tready stays high; the per-key update
// and the tick subtraction sit in one combinational pass between the two registers.
// Reset (rst_n low, synchronous): every key returns to the up phase with no
// stored duration, and both pipeline registers are emptied.

module key_debounce_press_timer
  import kdpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // key_index[1:0], key_level[2], tick[34:3], zero pad
  input  logic              in_tuser,   // operation[0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // press_duration[31:0], duration_valid[32], zero pad
  output logic [1:0]        out_tuser   // event_res[1:0]
);

  // Input register
  logic             s1_valid_r;
  logic             s1_op_r;
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_level_r;
  logic [TIN_W-1:0] s1_tick_r;

  // Result register
  logic             out_valid_r;
  key_result_t      out_res_r;

  // Per-key state
  phase_t               phase_r   [NUM_KEYS];
  logic [TICK_BITS-1:0] start_r   [NUM_KEYS];
  logic [TICK_BITS-1:0] dur_r     [NUM_KEYS];
  logic                 present_r [NUM_KEYS];

  logic        adv;
  logic        key_ok;
  key_state_t  cur;
  key_state_t  nxt;
  key_result_t unit_res;
  key_result_t res_nxt;

  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | adv;
  assign key_ok    = {30'd0, s1_key_r} < 32'(NUM_KEYS);

  // Select the addressed key's state
  always_comb begin
    cur = '{phase: PH_UP, start_tick: '0, duration: '0, present: 1'b0};
    if (key_ok) begin
      cur.phase      = phase_r[s1_key_r];
      cur.start_tick = start_r[s1_key_r];
      cur.duration   = dur_r[s1_key_r];
      cur.present    = present_r[s1_key_r];
    end
  end

  kdpt_key_unit u_key_unit (
    .operation (s1_op_r),
    .key_level (s1_level_r),
    .tick      (s1_tick_r),
    .cur       (cur),
    .nxt       (nxt),
    .res       (unit_res)
  );

  // Report no event and no duration for keys that do not exist
  always_comb begin
    res_nxt = unit_res;
    if (!key_ok) begin
      res_nxt = '{ev: EV_NONE, press_duration: '0, duration_valid: 1'b0};
    end
  end

  // Capture an input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_key_r   <= in_tdata[1:0];
      s1_level_r <= in_tdata[2];
      s1_tick_r  <= in_tdata[34:3];
      s1_op_r    <= in_tuser;
    end
  end

  // Write back key state as the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k]   <= PH_UP;
        present_r[k] <= 1'b0;
      end
    end else if (adv && s1_valid_r && key_ok) begin
      phase_r[s1_key_r]   <= nxt.phase;
      present_r[s1_key_r] <= nxt.present;
    end
    if (adv && s1_valid_r && key_ok) begin
      start_r[s1_key_r] <= nxt.start_tick;
      dur_r[s1_key_r]   <= nxt.duration;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (adv && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ev;
  assign out_tdata  = {7'd0, out_res_r.duration_valid, out_res_r.press_duration};

  // A result without a valid measurement carries a zero duration
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("duration reported without valid flag");

  // A release event always comes with a valid measurement
  a_up_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_UP |-> out_tdata[32])
    else $error("up event without valid duration");

  // A stalled result with a pending item blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && s1_valid_r |-> !in_tready)
    else $error("input accepted while pipeline is full");

  // A stalled result holds its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("result changed under stall");

endmodule

@@ tb/kdpt_press_checker.sv @@
`timescale 1ns / 1ps

module kdpt_press_checker
  import kdpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // key_index[1:0], key_level[2], tick[34:3], zero pad
  input  logic              in_tuser,   // operation[0]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,  // press_duration[31:0], duration_valid[32], zero pad
  input  logic [1:0]        out_tuser,  // event_res[1:0]
  output int                pending_results,
  output int                fail_count
);

  // Shadow copy of the per-key debounce state
  phase_t               key_phase_q [NUM_KEYS];
  logic [TICK_BITS-1:0] press_tick_q [NUM_KEYS];
  logic [TICK_BITS-1:0] held_ticks_q [NUM_KEYS];
  logic                 held_valid_q [NUM_KEYS];

  key_result_t predicted_key_results[$];

  // Advance one key's machine by one transaction and build the result it reports
  function automatic key_result_t next_key_result(logic op, logic [KEY_W-1:0] key,
                                                  logic level, logic [TIN_W-1:0] tick);
    key_result_t          res;
    logic                 pressed;
    logic [TICK_BITS-1:0] now;
    pressed = (level == 1'b0);
    now     = tick;
    res     = '0;
    res.ev  = EV_NONE;
    // Keys beyond the configured count are ignored
    if (key >= NUM_KEYS) return res;
    if (op == OP_CLEAR) begin
      held_valid_q[key] = 1'b0;
      held_ticks_q[key] = '0;
    end else begin
      case (key_phase_q[key])
        PH_UP: begin
          if (pressed) key_phase_q[key] = PH_FALLING;
        end
        PH_FALLING: begin
          if (pressed) begin
            key_phase_q[key]  = PH_DOWN;
            res.ev            = EV_DOWN;
            press_tick_q[key] = now;
          end else begin
            key_phase_q[key] = PH_UP;
          end
        end
        PH_DOWN: begin
          if (!pressed) key_phase_q[key] = PH_RISING;
        end
        default: begin
          if (!pressed) begin
            key_phase_q[key]  = PH_UP;
            res.ev            = EV_UP;
            // Modular difference, wraps through zero naturally
            held_ticks_q[key] = now - press_tick_q[key];
            held_valid_q[key] = 1'b1;
          end else begin
            key_phase_q[key] = PH_DOWN;
          end
        end
      endcase
    end
    res.duration_valid = held_valid_q[key];
    res.press_duration = held_valid_q[key] ? held_ticks_q[key][DUR_W-1:0] : '0;
    return res;
  endfunction

  task automatic check_field(input string field_name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, field_name, want, got);
    end
  endtask

  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_phase_q[k]  = PH_UP;
        press_tick_q[k] = '0;
        held_ticks_q[k] = '0;
        held_valid_q[k] = 1'b0;
      end
      predicted_key_results.delete();
      fail_count = 0;
    end else begin
      // Predict on every accepted input transaction
      if (in_tvalid && in_tready)
        predicted_key_results.push_back(next_key_result(in_tuser, in_tdata[1:0],
                                                        in_tdata[2], in_tdata[34:3]));
      // Compare every accepted result transaction against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (predicted_key_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, got event %0d duration 0x%0h",
                   $time, out_tuser, out_tdata[31:0]);
        end else begin
          want = predicted_key_results.pop_front();
          check_field("event_res", 32'(want.ev), 32'(out_tuser));
          check_field("press_duration", want.press_duration, out_tdata[31:0]);
          check_field("duration_valid", 32'(want.duration_valid), 32'(out_tdata[32]));
        end
      end
    end
    pending_results <= predicted_key_results.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import kdpt_pkg::*;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata   = '0;  // key_index[1:0], key_level[2], tick[34:3], zero pad
  logic              in_tuser   = OP_POLL;  // operation[0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;  // press_duration[31:0], duration_valid[32], zero pad
  logic [1:0]        out_tuser;  // event_res[1:0]

  int pending_results;
  int fail_count;

  // Idle rates in percent, and the long receiver hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  // Intended level of each key and the running tick for random traffic
  logic [NUM_KEYS-1:0] key_target = '1;
  logic [TIN_W-1:0]    tick_now   = '0;

  always #4 clk = ~clk;

  key_debounce_press_timer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  kdpt_press_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  // Receiver: random backpressure, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req   <= 1'b0;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one transaction after a random gap, return at the edge that accepts it
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic level, input logic [TIN_W-1:0] tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DW-KEY_W-1-TIN_W){1'b0}}, tick, level, key};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly clean press and release runs, with bounce, clears and tick jumps mixed in
  task automatic send_random_item();
    logic [KEY_W-1:0] key;
    logic             op;
    logic             level;
    key = KEY_W'($urandom_range(NUM_KEYS - 1));
    op  = ($urandom_range(99) < 5) ? OP_CLEAR : OP_POLL;
    if ($urandom_range(99) < 8) key_target[key] = ~key_target[key];
    level = key_target[key];
    if ($urandom_range(99) < 12) level = ~level;
    if ($urandom_range(99) < 5) tick_now = $urandom();
    else tick_now = tick_now + TIN_W'($urandom_range(5000));
    send_item(op, key, level, tick_now);
  endtask

  // Hold the sender until every predicted result has come back, then let the pipe settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: clear with nothing stored
    send_item(OP_CLEAR, 2'd0, 1'b1, 32'h0);
    // Clean press with release bounce, duration wrapping through zero
    send_item(OP_POLL,  2'd0, 1'b0, 32'hFFFF_FFF0);
    send_item(OP_POLL,  2'd0, 1'b0, 32'hFFFF_FFF8);
    send_item(OP_POLL,  2'd0, 1'b1, $urandom());
    send_item(OP_POLL,  2'd0, 1'b0, $urandom());
    send_item(OP_POLL,  2'd0, 1'b1, $urandom());
    send_item(OP_POLL,  2'd0, 1'b1, 32'h0000_0018);
    send_item(OP_CLEAR, 2'd0, 1'b0, $urandom());
    // Press bounce back to up, then press, clear while down, release on the same tick
    send_item(OP_POLL,  2'd1, 1'b0, $urandom());
    send_item(OP_POLL,  2'd1, 1'b1, $urandom());
    send_item(OP_POLL,  2'd1, 1'b0, $urandom());
    send_item(OP_POLL,  2'd1, 1'b0, 32'h1234_5678);
    send_item(OP_CLEAR, 2'd1, 1'b1, $urandom());
    send_item(OP_POLL,  2'd1, 1'b1, $urandom());
    send_item(OP_POLL,  2'd1, 1'b1, 32'h1234_5678);
    // Largest duration: release one tick before the press
    send_item(OP_POLL,  2'd2, 1'b0, $urandom());
    send_item(OP_POLL,  2'd2, 1'b0, 32'h0000_0001);
    send_item(OP_POLL,  2'd2, 1'b1, $urandom());
    send_item(OP_POLL,  2'd2, 1'b1, 32'h0000_0000);
    // Press at the top tick value, release half way round
    send_item(OP_POLL,  2'd3, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_POLL,  2'd3, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_POLL,  2'd3, 1'b1, 32'h0000_0000);
    send_item(OP_POLL,  2'd3, 1'b1, 32'h7FFF_FFFF);
    send_item(OP_POLL,  2'd3, 1'b1, 32'hAAAA_5555);
    send_item(OP_CLEAR, 2'd2, 1'b0, 32'h5555_AAAA);
    wait_drained();

    // Fill the pipe against a long receiver hold-off
    hold_req <= 1'b1;
    for (int n = 0; n < 60; n++) send_random_item();
    wait_drained();

    // Random traffic under three idling patterns
    send_idle_pct <= 30;
    recv_idle_pct <= 54;
    for (int n = 0; n < 570; n++) send_random_item();
    send_idle_pct <= 54;
    recv_idle_pct <= 30;
    for (int n = 0; n < 570; n++) send_random_item();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    for (int n = 0; n < 560; n++) send_random_item();
    wait_drained();

    if (fail_count == 0) begin
      $display("[key_debounce_press_timer] OK");
    end else begin
      $display("[key_debounce_press_timer] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[key_debounce_press_timer] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/kdpt_pkg.sv
design/kdpt_key_unit.sv
design/key_debounce_press_timer.sv
tb/kdpt_press_checker.sv
tb/testbench.sv
